[hw/rtl/spq_pkg.sv]
// Shared constants and types for the scale pitch quantizer.
package spq_pkg;

  // Default geometry.
  localparam int SPQ_NOTE_SLOTS = 63;
  localparam int SPQ_DAC_MAX    = 4095;

  // Register reset values.
  localparam logic [11:0] SPQ_MASK_RST = 12'hFFF;
  localparam logic [3:0]  SPQ_SENS_RST = 4'd4;
  localparam logic [2:0]  SPQ_OCT_RST  = 3'd2;

  // Input scaling: (16 + sensitivity) / 20. The division by 20 is a shift by two followed
  // by a multiply with ceil(2^18 / 5), which is exact over the whole product range.
  localparam int SPQ_GAIN_BASE   = 16;
  localparam int SPQ_RECIP_5     = 52429;
  localparam int SPQ_RECIP_SHIFT = 18;
  localparam int SPQ_SCALE_MAX   = 4095;

  // Note thresholds are 68 * slot - 32.
  localparam int SPQ_STEP   = 68;
  localparam int SPQ_OFFSET = 32;

  // Output code is semitones * 273 / 4. Octave 2 is the zero shift.
  localparam int SPQ_SEMIS_OCT = 12;
  localparam int SPQ_OCT_BASE  = 24;
  localparam int SPQ_CODE_MUL  = 273;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_NOTE_MASK   = 2'd0,
    CFG_SENSITIVITY = 2'd1,
    CFG_OCTAVE      = 2'd2
  } spq_cfg_idx_t;

endpackage

[hw/rtl/scale_pitch_quantizer.sv]
// Top level of the scale pitch quantizer: note table memory, build sweep and search.
//
//   Channel  Ports                                          Transfer when
//   -------  ---------------------------------------------  ----------------------
//   input    start, busy, in_sample                         start high, busy low
//   result   out_valid, out_dac_code, out_note_number,      out_valid high (one
//            out_no_note                                    cycle, no stall)
//   config   cfg_we, cfg_index, cfg_wdata                   cfg_we high
//
// A sample passes from its transfer through S_MUL and S_DIV to S_SCAN, where the search
// walks the enabled note slots until it finds the first threshold above the scaled sample
// (at most the enabled count, up to NOTE_SLOTS), and then through S_CODE to its result
// strobe. The walk reads one table entry per cycle from the note table. With an empty
// mask the result follows in the next cycle. After reset, and after every note_mask
// write, the table is rebuilt in a sweep over all NOTE_SLOTS slots while busy stays high.
// The result side cannot stall, so every result is presented for exactly one cycle.
module scale_pitch_quantizer
  import spq_pkg::*;
#(
  parameter int NOTE_SLOTS = SPQ_NOTE_SLOTS,
  parameter int DAC_MAX    = SPQ_DAC_MAX
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [11:0]                     in_sample,
  output logic                            out_valid,
  output logic [$clog2(DAC_MAX+1)-1:0]    out_dac_code,
  output logic [$clog2(NOTE_SLOTS)-1:0]   out_note_number,
  output logic                            out_no_note,
  input  logic                            cfg_we,
  input  logic [1:0]                      cfg_index,
  input  logic [11:0]                     cfg_wdata
);

  localparam int AW  = $clog2(NOTE_SLOTS);
  localparam int CW  = $clog2(NOTE_SLOTS + 1);
  localparam int DW  = $clog2(DAC_MAX + 1);
  localparam int UW0 = $clog2(SPQ_STEP * NOTE_SLOTS + 1);
  // Threshold compares run in the offset domain (68 * slot against x + 32).
  localparam int UW  = (UW0 > 13) ? UW0 : 13;

  typedef enum logic [2:0] {
    S_BUILD, S_IDLE, S_MUL, S_DIV, S_SCAN, S_CODE
  } state_t;

  state_t state_r;

  // Configuration registers.
  logic [11:0] mask_r;
  logic [3:0]  sens_r;
  logic [2:0]  oct_r;

  // Table build sweep: slot counter, semitone within the octave, enabled count.
  logic [AW-1:0] bj_r;
  logic [3:0]    semi_r;
  logic [CW-1:0] cnt_r;

  // Sample path.
  logic [11:0]   samp_r;
  logic [16:0]   prod_r;
  logic [12:0]   xo_r;

  // Search.
  logic [CW-1:0] idx_r;
  logic          chk_v_r;
  logic          first_r;
  logic [UW-1:0] prev_u_r;
  logic [AW-1:0] prev_slot_r;
  logic [AW-1:0] pick_r;

  // Note table: entry k holds the slot number of the k-th enabled note.
  logic [AW-1:0] tbl_mem [NOTE_SLOTS];
  logic [AW-1:0] rd_q_r;

  // Output registers.
  logic          out_valid_r;
  logic [DW-1:0] dac_r;
  logic [AW-1:0] note_r;
  logic          no_note_r;

  // Memory control. Building and searching never overlap, so a read never meets a
  // write to the same entry and no forwarding path is needed.
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic          rd_en;
  logic [AW-1:0] rd_addr;

  assign wr_en   = (state_r == S_BUILD) && mask_r[semi_r];
  assign wr_addr = cnt_r[AW-1:0];
  assign rd_en   = (state_r == S_DIV) || ((state_r == S_SCAN) && (idx_r < cnt_r));
  assign rd_addr = (state_r == S_DIV) ? '0 : idx_r[AW-1:0];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      tbl_mem[wr_addr] <= bj_r;
    end
    if (rd_en) begin
      rd_q_r <= tbl_mem[rd_addr];
    end
  end

  // Scaled sample: floor(prod / 20), saturated to the 12-bit range.
  logic [30:0] quot_full;
  logic [12:0] quot;
  logic [11:0] x_sat;

  assign quot_full = 31'(prod_r[16:2]) * 31'(SPQ_RECIP_5);
  assign quot      = 13'(quot_full >> SPQ_RECIP_SHIFT);
  assign x_sat     = (quot > 13'(SPQ_SCALE_MAX)) ? 12'(SPQ_SCALE_MAX) : quot[11:0];

  // Threshold of the entry that arrived from the table this cycle, offset by +32.
  logic [UW-1:0] cur_u;
  logic [UW-1:0] xo_ext;
  logic          hit;
  logic          upper_wins;

  assign cur_u  = UW'(rd_q_r) * UW'(SPQ_STEP);
  assign xo_ext = UW'(xo_r);
  assign hit    = chk_v_r && (cur_u > xo_ext);
  // The upper note wins when the distance below is at least the distance above,
  // that is when 2 * x >= lower + upper threshold.
  assign upper_wins = ({1'b0, xo_ext} << 1) >= ((UW+1)'(prev_u_r) + (UW+1)'(cur_u));

  // Output code from the chosen slot and the octave shift.
  logic [9:0]  sum_u;
  logic [7:0]  semis;
  logic        below_zero;
  logic [17:0] code_full;
  logic [17:0] code;
  logic [DW-1:0] dac_c;

  assign sum_u      = 10'(pick_r) + 10'(oct_r) * 10'(SPQ_SEMIS_OCT);
  assign below_zero = sum_u < 10'(SPQ_OCT_BASE);
  assign semis      = 8'(sum_u - 10'(SPQ_OCT_BASE));
  assign code_full  = 18'(semis) * 18'(SPQ_CODE_MUL);
  assign code       = code_full >> 2;
  assign dac_c      = below_zero ? '0 :
                      (code > 18'(DAC_MAX)) ? DW'(DAC_MAX) : DW'(code);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_BUILD;
      mask_r      <= SPQ_MASK_RST;
      sens_r      <= SPQ_SENS_RST;
      oct_r       <= SPQ_OCT_RST;
      bj_r        <= '0;
      semi_r      <= '0;
      cnt_r       <= '0;
      chk_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;

      case (state_r)
        S_BUILD: begin
          if (mask_r[semi_r]) begin
            cnt_r <= cnt_r + 1'b1;
          end
          bj_r   <= bj_r + 1'b1;
          semi_r <= (semi_r == 4'(SPQ_SEMIS_OCT - 1)) ? '0 : semi_r + 1'b1;
          if (bj_r == AW'(NOTE_SLOTS - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            samp_r <= in_sample;
            if (cnt_r == '0) begin
              // Empty mask: no note to choose, answer at once.
              out_valid_r <= 1'b1;
              dac_r       <= '0;
              note_r      <= '0;
              no_note_r   <= 1'b1;
            end else begin
              state_r <= S_MUL;
            end
          end
        end
        S_MUL: begin
          prod_r  <= 17'(samp_r) * 17'(5'(SPQ_GAIN_BASE) + 5'(sens_r));
          state_r <= S_DIV;
        end
        S_DIV: begin
          // Entry 0 is read here, so the walk starts with data in hand.
          xo_r    <= 13'(x_sat) + 13'(SPQ_OFFSET);
          idx_r   <= CW'(1);
          chk_v_r <= 1'b1;
          first_r <= 1'b1;
          state_r <= S_SCAN;
        end
        S_SCAN: begin
          chk_v_r <= rd_en;
          if (rd_en) begin
            idx_r <= idx_r + 1'b1;
          end
          if (hit) begin
            // First threshold above the sample: choose between it and the one before.
            pick_r  <= (first_r || upper_wins) ? rd_q_r : prev_slot_r;
            chk_v_r <= 1'b0;
            state_r <= S_CODE;
          end else if (chk_v_r) begin
            prev_u_r    <= cur_u;
            prev_slot_r <= rd_q_r;
            first_r     <= 1'b0;
          end else begin
            // Sample is at or above the last note.
            pick_r  <= prev_slot_r;
            state_r <= S_CODE;
          end
        end
        S_CODE: begin
          out_valid_r <= 1'b1;
          dac_r       <= dac_c;
          note_r      <= pick_r;
          no_note_r   <= 1'b0;
          state_r     <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase

      // Configuration writes; a new mask restarts the table build.
      if (cfg_we) begin
        case (cfg_index)
          CFG_NOTE_MASK: begin
            mask_r  <= cfg_wdata;
            bj_r    <= '0;
            semi_r  <= '0;
            cnt_r   <= '0;
            state_r <= S_BUILD;
          end
          CFG_SENSITIVITY: begin
            sens_r <= cfg_wdata[3:0];
          end
          CFG_OCTAVE: begin
            oct_r <= cfg_wdata[2:0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  assign busy            = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_dac_code    = dac_r;
  assign out_note_number = note_r;
  assign out_no_note     = no_note_r;

endmodule
